// ===== sv/aspb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package aspb_pkg;

	// Item kinds carried in the input tuser field.
	localparam logic [1:0] OP_SAMPLE = 2'd0;
	localparam logic [1:0] OP_SWAP   = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	// Field widths.
	localparam int OP_W    = 2;
	localparam int CODE_W  = 12;
	localparam int IDX_W   = 10;
	localparam int VOLT_W  = 17;
	localparam int ACC_W   = 25;
	localparam int CNT_W   = 11;
	localparam int TOTAL_W = 48;
	localparam int WGT_W   = 16;

	// Reset value of the smoothing weight, about 0.999 in Q0.16.
	localparam logic [WGT_W-1:0] WEIGHT_RESET = 16'd65470;

	// Code to volts: (code * 1.8 V in Q16 + 2047) / 4095.
	localparam int unsigned FULL_SCALE_Q16 = 117965;
	localparam int unsigned CODE_MAX       = 4095;
	localparam int unsigned CODE_ROUND     = 2047;

	// The scaled code stays below 2^29, so a 30-bit reciprocal with a 41-bit
	// shift gives the exact quotient for every code.
	localparam int PROD_W      = 29;
	localparam int RECIP_W     = 30;
	localparam int RECIP_SHIFT = 41;
	localparam longint unsigned RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(CODE_MAX) - 64'd1) / 64'(CODE_MAX);
	localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_FULL);

endpackage

`default_nettype wire

// ===== sv/aspb_bank_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One sample bank: one write port and one read port, registered read data.
module aspb_bank_ram #(
	parameter int DEPTH = 1024
) (
	input  wire                           clk,
	input  wire                           wr_en,
	input  wire  [$clog2(DEPTH)-1:0]      wr_addr,
	input  wire  [aspb_pkg::VOLT_W-1:0]   wr_data,
	input  wire                           rd_en,
	input  wire  [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [aspb_pkg::VOLT_W-1:0]   rd_data
);

	logic [aspb_pkg::VOLT_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/aspb_convert.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Two-stage conversion of a 12-bit code to volts in Q16.
module aspb_convert (
	input  wire                           clk,
	input  wire                           en_s1,
	input  wire                           en_s2,
	input  wire  [aspb_pkg::CODE_W-1:0]   code,
	output logic [aspb_pkg::VOLT_W-1:0]   volt_s2
);

	localparam int QPROD_W = aspb_pkg::PROD_W + aspb_pkg::RECIP_W;

	logic [aspb_pkg::PROD_W-1:0] scaled_s1;
	logic [QPROD_W-1:0]          quot_prod;

	// First stage: scale by full scale and add the rounding offset.
	always_ff @(posedge clk) begin
		if (en_s1) begin
			scaled_s1 <= aspb_pkg::PROD_W'(code) * aspb_pkg::PROD_W'(aspb_pkg::FULL_SCALE_Q16)
				+ aspb_pkg::PROD_W'(aspb_pkg::CODE_ROUND);
		end
	end

	// Second stage: divide by the code range through the reciprocal.
	assign quot_prod = QPROD_W'(scaled_s1) * QPROD_W'(aspb_pkg::RECIP_MULT);

	always_ff @(posedge clk) begin
		if (en_s2) begin
			volt_s2 <= quot_prod[aspb_pkg::RECIP_SHIFT +: aspb_pkg::VOLT_W];
		end
	end

endmodule

`default_nettype wire

// ===== sv/aspb_average.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Exponential average, kept with eight extra fraction bits.
// The blend w*acc + (1-w)*target is rewritten as acc + (1-w)*(target-acc),
// so the loop holds a single multiplier.
module aspb_average (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           update,
	input  wire  [aspb_pkg::VOLT_W-1:0]   volt,
	input  wire  [aspb_pkg::WGT_W-1:0]    weight,
	output logic [aspb_pkg::VOLT_W-1:0]   avg_out
);

	localparam int ACC_W  = aspb_pkg::ACC_W;
	localparam int DIFF_W = ACC_W + 1;
	localparam int GAIN_W = aspb_pkg::WGT_W + 2;
	localparam int MUL_W  = DIFF_W + GAIN_W;

	logic [ACC_W-1:0]         acc_q;
	logic                     seeded_q;
	logic [ACC_W-1:0]         target;
	logic [aspb_pkg::WGT_W:0] gain;
	logic signed [DIFF_W-1:0] diff;
	logic signed [GAIN_W-1:0] gain_s;
	logic signed [MUL_W-1:0]  prod;
	logic signed [MUL_W-1:0]  prod_rnd;
	logic signed [MUL_W-1:0]  step;
	logic [ACC_W-1:0]         acc_new;
	logic [ACC_W-1:0]         acc_src;
	logic [ACC_W:0]           acc_rnd;

	// Weight of the new sample and the signed distance to the target.
	assign target   = {volt, 8'd0};
	assign gain     = (17'd1 << aspb_pkg::WGT_W) - {1'b0, weight};
	assign gain_s   = $signed({1'b0, gain});
	assign diff     = $signed({1'b0, target}) - $signed({1'b0, acc_q});
	assign prod     = diff * gain_s;
	assign prod_rnd = prod + $signed(MUL_W'(32768));
	assign step     = prod_rnd >>> aspb_pkg::WGT_W;

	// The first sample seeds the average.
	assign acc_new = seeded_q ? (acc_q + step[ACC_W-1:0]) : target;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			seeded_q <= 1'b0;
		end else if (update) begin
			acc_q    <= acc_new;
			seeded_q <= 1'b1;
		end
	end

	// Rounded average as seen after this transaction.
	assign acc_src = update ? acc_new : acc_q;
	assign acc_rnd = {1'b0, acc_src} + (ACC_W + 1)'(128);
	assign avg_out = acc_rnd[8 +: aspb_pkg::VOLT_W];

endmodule

`default_nettype wire

// ===== sv/adc_sample_ema_pingpong_buffer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Accepted inputs pass through stage one, stage two and the output register in turn.
// Throughput: one item per cycle while m_tready is high; one access per bank per cycle.
// Each pipeline stage moves whenever the stage after it is empty or moving.
// Reset clears counters, bank select, average and pipeline, and sets the weight to 65470.
// Bank memories are not cleared; entries beyond the history count are never read.
module adc_sample_ema_pingpong_buffer #(
	parameter int BANK_DEPTH = 1024
) (
	input  wire          clk,
	input  wire          arst_n,
	// Configuration: smoothing weight in Q0.16.
	input  wire          cfg_wen,
	input  wire  [15:0]  cfg_wdata,
	// Input stream.
	input  wire          s_tvalid,
	output logic         s_tready,
	input  wire  [23:0]  s_tdata,   // [11:0] sample_code, [21:12] read_index, rest zero
	input  wire  [1:0]   s_tuser,   // [1:0] operation
	// Result stream.
	output logic         m_tvalid,
	input  wire          m_tready,
	output logic [103:0] m_tdata,   // [16:0] voltage, [33:17] average, [44:34] history_count,
	                                // [55:45] current_count, [103:56] total_samples
	output logic [1:0]   m_tuser    // [0] dropped, [1] index_ok
);

	localparam int AW      = $clog2(BANK_DEPTH);
	localparam int CW      = $clog2(BANK_DEPTH + 1);
	localparam int VOLT_W  = aspb_pkg::VOLT_W;
	localparam int CNT_W   = aspb_pkg::CNT_W;
	localparam int TOTAL_W = aspb_pkg::TOTAL_W;

	typedef struct packed {
		logic [aspb_pkg::OP_W-1:0] op;
		logic                      store;
		logic                      drop;
		logic                      ok;
		logic                      wbank;
		logic [AW-1:0]             waddr;
		logic                      rbank;
		logic [AW-1:0]             raddr;
		logic [CNT_W-1:0]          hist;
		logic [CNT_W-1:0]          cur;
		logic [TOTAL_W-1:0]        total;
	} item_t;

	// Architectural state.
	logic                       bank_q;
	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              hist_q;
	logic [TOTAL_W-1:0]         total_q;
	logic [aspb_pkg::WGT_W-1:0] weight_q;

	logic                       bank_d;
	logic [CW-1:0]              fill_d;
	logic [CW-1:0]              hist_d;
	logic [TOTAL_W-1:0]         total_d;

	// Input fields.
	logic [aspb_pkg::OP_W-1:0]   in_op;
	logic [aspb_pkg::CODE_W-1:0] in_code;
	logic [aspb_pkg::IDX_W-1:0]  in_idx;
	logic                        accept;
	item_t                       item_d;

	// Pipeline.
	logic  vld_s1, vld_s2, vld_s3;
	item_t item_s1, item_s2;
	logic  rdy_s1, rdy_s2, rdy_s3;
	logic  mv12, mv23;

	logic [VOLT_W-1:0]  volt_s2;
	logic [VOLT_W-1:0]  avg_next;
	logic [VOLT_W-1:0]  rd_data0, rd_data1;
	logic               upd_avg;
	logic               rd_now;

	logic [aspb_pkg::OP_W-1:0] op_s3;
	logic [VOLT_W-1:0]  volt_s3;
	logic [VOLT_W-1:0]  avg_s3;
	logic [CNT_W-1:0]   hist_s3;
	logic [CNT_W-1:0]   cur_s3;
	logic [TOTAL_W-1:0] total_s3;
	logic               drop_s3;
	logic               ok_s3;
	logic               use_rd_s3;
	logic               rbank_s3;
	logic [VOLT_W-1:0]  volt_out;

	assign in_op   = s_tuser[1:0];
	assign in_code = s_tdata[11:0];
	assign in_idx  = s_tdata[21:12];

	// Stage handshakes: a stage takes new data when empty or when it moves on.
	assign rdy_s3   = !vld_s3 || m_tready;
	assign rdy_s2   = !vld_s2 || rdy_s3;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign accept   = s_tvalid && s_tready;
	assign mv12     = vld_s1 && rdy_s2;
	assign mv23     = vld_s2 && rdy_s3;

	// Counter and bank updates for the incoming transaction.
	always_comb begin
		bank_d       = bank_q;
		fill_d       = fill_q;
		hist_d       = hist_q;
		total_d      = total_q;
		item_d       = '0;
		item_d.op    = in_op;
		item_d.wbank = bank_q;
		item_d.waddr = AW'(fill_q);
		item_d.rbank = ~bank_q;
		item_d.raddr = AW'(in_idx);
		case (in_op)
			aspb_pkg::OP_SAMPLE: begin
				if (32'(fill_q) < BANK_DEPTH) begin
					fill_d       = fill_q + CW'(1);
					item_d.store = 1'b1;
				end else begin
					item_d.drop = 1'b1;
				end
				total_d = total_q + TOTAL_W'(1);
			end
			aspb_pkg::OP_SWAP: begin
				bank_d = ~bank_q;
				hist_d = fill_q;
				fill_d = '0;
			end
			aspb_pkg::OP_READ: begin
				item_d.ok = (32'(in_idx) < 32'(hist_q)) && (32'(in_idx) < BANK_DEPTH);
			end
			default: begin
			end
		endcase
		item_d.hist  = CNT_W'(hist_d);
		item_d.cur   = CNT_W'(fill_d);
		item_d.total = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q  <= 1'b0;
			fill_q  <= '0;
			hist_q  <= '0;
			total_q <= '0;
		end else if (accept) begin
			bank_q  <= bank_d;
			fill_q  <= fill_d;
			hist_q  <= hist_d;
			total_q <= total_d;
		end
	end

	// Smoothing weight register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= aspb_pkg::WEIGHT_RESET;
		end else if (cfg_wen) begin
			weight_q <= cfg_wdata;
		end
	end

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept || (vld_s1 && !rdy_s2);
			vld_s2 <= mv12 || (vld_s2 && !rdy_s3);
			vld_s3 <= mv23 || (vld_s3 && !m_tready);
		end
	end

	// Stage payloads.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
		if (mv12) begin
			item_s2 <= item_s1;
		end
	end

	aspb_convert u_convert (
		.clk     (clk),
		.en_s1   (accept),
		.en_s2   (mv12),
		.code    (in_code),
		.volt_s2 (volt_s2)
	);

	// Memory accesses and the average update, all in item order at stage two.
	assign upd_avg = mv23 && (item_s2.op == aspb_pkg::OP_SAMPLE);
	assign rd_now  = mv23 && (item_s2.op == aspb_pkg::OP_READ) && item_s2.ok;

	aspb_average u_average (
		.clk     (clk),
		.arst_n  (arst_n),
		.update  (upd_avg),
		.volt    (volt_s2),
		.weight  (weight_q),
		.avg_out (avg_next)
	);

	aspb_bank_ram #(.DEPTH(BANK_DEPTH)) u_bank0 (
		.clk     (clk),
		.wr_en   (mv23 && item_s2.store && !item_s2.wbank),
		.wr_addr (item_s2.waddr),
		.wr_data (volt_s2),
		.rd_en   (rd_now && !item_s2.rbank),
		.rd_addr (item_s2.raddr),
		.rd_data (rd_data0)
	);

	aspb_bank_ram #(.DEPTH(BANK_DEPTH)) u_bank1 (
		.clk     (clk),
		.wr_en   (mv23 && item_s2.store && item_s2.wbank),
		.wr_addr (item_s2.waddr),
		.wr_data (volt_s2),
		.rd_en   (rd_now && item_s2.rbank),
		.rd_addr (item_s2.raddr),
		.rd_data (rd_data1)
	);

	// Output register.
	always_ff @(posedge clk) begin
		if (mv23) begin
			op_s3     <= item_s2.op;
			volt_s3   <= (item_s2.op == aspb_pkg::OP_SAMPLE) ? volt_s2 : '0;
			avg_s3    <= avg_next;
			hist_s3   <= item_s2.hist;
			cur_s3    <= item_s2.cur;
			total_s3  <= item_s2.total;
			drop_s3   <= item_s2.drop;
			ok_s3     <= item_s2.ok;
			use_rd_s3 <= (item_s2.op == aspb_pkg::OP_READ) && item_s2.ok;
			rbank_s3  <= item_s2.rbank;
		end
	end

	// Read data comes straight from the bank that was read.
	assign volt_out = use_rd_s3 ? (rbank_s3 ? rd_data1 : rd_data0) : volt_s3;

	assign m_tvalid = vld_s3;
	assign m_tdata  = {total_s3, cur_s3, hist_s3, avg_s3, volt_out};
	assign m_tuser  = {ok_s3, drop_s3};

	// Fill levels never pass the bank depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(fill_q) <= BANK_DEPTH) && (32'(hist_q) <= BANK_DEPTH))
		else $error("bank fill level beyond depth");

	// A swap leaves an empty current bank.
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_op == aspb_pkg::OP_SWAP) |=> (fill_q == '0))
		else $error("current bank not empty after swap");

	// A dropped sample is reported only with a full current bank.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata[55:45] == CNT_W'(BANK_DEPTH)))
		else $error("sample dropped while bank not full");

	// A read outside the history returns zero volts and no data from memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (op_s3 == aspb_pkg::OP_READ) && !m_tuser[1] |->
			(m_tdata[16:0] == '0) && !use_rd_s3)
		else $error("out of range read returned data");

	// Dropped and index flags never come together.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("dropped and index flags both set");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int BANK_DEPTH = 1024;
	localparam int LATENCY = 3;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// One queued input transaction and the idle cycles that come before it.
	typedef struct {
		logic [aspb_pkg::OP_W-1:0]   op;
		logic [aspb_pkg::CODE_W-1:0] code;
		logic [aspb_pkg::IDX_W-1:0]  idx;
		int unsigned                 gap;
	} feed_t;

	// One result transaction, field by field.
	typedef struct {
		logic [aspb_pkg::VOLT_W-1:0]  voltage;
		logic [aspb_pkg::VOLT_W-1:0]  average;
		logic [aspb_pkg::CNT_W-1:0]   hist_count;
		logic [aspb_pkg::CNT_W-1:0]   cur_count;
		logic [aspb_pkg::TOTAL_W-1:0] total;
		logic                         dropped;
		logic                         index_ok;
	} reading_t;

	logic           clk;
	logic           arst_n = 1'b0;
	logic           cfg_wen = 1'b0;
	logic [15:0]    cfg_wdata = '0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [23:0]    s_tdata = '0;
	logic [1:0]     s_tuser = '0;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [103:0]   m_tdata;
	logic [1:0]     m_tuser;

	feed_t          sample_feed[$];
	reading_t       pending_readings[$];
	int unsigned    errors = 0;
	int unsigned    idle_run = 0;
	int unsigned    stall_left = 0;
	int unsigned    quiet_cycles = 0;
	bit             calm = 1'b0;

	// Predicted block state.
	logic [aspb_pkg::VOLT_W-1:0]  bank_store [0:1][0:BANK_DEPTH-1];
	logic                         active_sel = 1'b0;
	int unsigned                  fill_level = 0;
	int unsigned                  hist_level = 0;
	logic [aspb_pkg::TOTAL_W-1:0] samples_seen = '0;
	logic [aspb_pkg::ACC_W-1:0]   avg_acc = '0;
	bit                           avg_seeded = 1'b0;
	logic [aspb_pkg::WGT_W-1:0]   weight_q16 = aspb_pkg::WEIGHT_RESET;

	// Counts as the stimulus planner sees them, used to aim history reads.
	int unsigned        plan_fill = 0;
	int unsigned        plan_hist = 0;

	adc_sample_ema_pingpong_buffer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Applies one accepted item to the predicted state and returns its result.
	function automatic reading_t compute_reading(logic [aspb_pkg::OP_W-1:0] op,
			logic [aspb_pkg::CODE_W-1:0] code, logic [aspb_pkg::IDX_W-1:0] idx);
		reading_t r;
		longint unsigned volts;
		longint unsigned mix;
		volts = 0;
		r.dropped = 1'b0;
		r.index_ok = 1'b0;
		case (op)
			aspb_pkg::OP_SAMPLE: begin
				volts = (64'(code) * 64'(aspb_pkg::FULL_SCALE_Q16)
					+ 64'(aspb_pkg::CODE_ROUND)) / 64'(aspb_pkg::CODE_MAX);
				if (fill_level < BANK_DEPTH) begin
					bank_store[active_sel][fill_level] = volts[aspb_pkg::VOLT_W-1:0];
					fill_level++;
				end else begin
					r.dropped = 1'b1;
				end
				samples_seen = samples_seen + 1'b1;
				// The first sample seeds the average; later ones blend in by weight.
				if (!avg_seeded) begin
					avg_acc = aspb_pkg::ACC_W'(volts << 8);
					avg_seeded = 1'b1;
				end else begin
					mix = 64'(weight_q16) * 64'(avg_acc)
						+ (64'd65536 - 64'(weight_q16)) * (volts << 8) + 64'd32768;
					avg_acc = mix[aspb_pkg::ACC_W+15:16];
				end
			end
			aspb_pkg::OP_SWAP: begin
				active_sel = ~active_sel;
				hist_level = fill_level;
				fill_level = 0;
			end
			aspb_pkg::OP_READ: begin
				if (idx < hist_level) begin
					r.index_ok = 1'b1;
					volts = bank_store[~active_sel][idx];
				end
			end
			default: ;
		endcase
		r.voltage = volts[aspb_pkg::VOLT_W-1:0];
		mix = 64'(avg_acc) + 64'd128;
		r.average = mix[aspb_pkg::VOLT_W+7:8];
		r.hist_count = aspb_pkg::CNT_W'(hist_level);
		r.cur_count = aspb_pkg::CNT_W'(fill_level);
		r.total = samples_seen;
		return r;
	endfunction

	task automatic check_field(string label, longint unsigned want, longint unsigned got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
		end
	endtask

	// Driver: presents queued items, honoring each one's idle gap.
	always @(posedge clk or negedge arst_n) begin : drive
		feed_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			idle_run <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_readings.push_back(compute_reading(s_tuser, s_tdata[11:0],
					s_tdata[21:12]));
			end
			if (!s_tvalid || s_tready) begin
				if (sample_feed.size() != 0 && idle_run >= sample_feed[0].gap) begin
					item = sample_feed.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= item.op;
					s_tdata <= {2'b00, item.idx, item.code};
					idle_run <= 0;
				end else begin
					s_tvalid <= 1'b0;
					idle_run <= idle_run + 1;
				end
			end
		end
	end

	// Monitor: stalls the result stream at random and checks every transaction.
	always @(posedge clk or negedge arst_n) begin : collect
		reading_t want;
		int unsigned hold;
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_left <= 0;
		end else begin
			hold = stall_left;
			if (m_tvalid && m_tready) begin
				if (pending_readings.size() == 0) begin
					errors++;
					$display("%0t: unexpected result, expected none, actual %h/%h", $time,
						m_tdata, m_tuser);
					// A result with no input behind it means the stream is lost.
					$display("testbench: errors");
					$finish;
				end else begin
					want = pending_readings.pop_front();
					check_field("voltage", want.voltage, m_tdata[16:0]);
					check_field("average", want.average, m_tdata[33:17]);
					check_field("history_count", want.hist_count, m_tdata[44:34]);
					check_field("current_count", want.cur_count, m_tdata[55:45]);
					check_field("total_samples", want.total, m_tdata[103:56]);
					check_field("dropped", want.dropped, m_tuser[0]);
					check_field("index_ok", want.index_ok, m_tuser[1]);
				end
				hold = calm ? 0 : $urandom_range(0, 6);
			end
			if (hold != 0) begin
				m_tready <= 1'b0;
				stall_left <= hold - 1;
			end else begin
				m_tready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// Watchdog: ends the run when no transaction moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic feed(logic [aspb_pkg::OP_W-1:0] op, logic [aspb_pkg::CODE_W-1:0] code,
			logic [aspb_pkg::IDX_W-1:0] idx);
		feed_t item;
		item.op = op;
		item.code = code;
		item.idx = idx;
		item.gap = calm ? 0 : $urandom_range(0, 6);
		sample_feed.push_back(item);
		case (op)
			aspb_pkg::OP_SAMPLE: if (plan_fill < BANK_DEPTH) plan_fill++;
			aspb_pkg::OP_SWAP: begin
				plan_hist = plan_fill;
				plan_fill = 0;
			end
			default: ;
		endcase
	endtask

	function automatic logic [aspb_pkg::CODE_W-1:0] pick_code();
		int unsigned roll;
		roll = $urandom_range(0, 19);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		return aspb_pkg::CODE_W'($urandom);
	endfunction

	function automatic logic [aspb_pkg::IDX_W-1:0] pick_history_index();
		if (plan_hist != 0 && $urandom_range(0, 9) != 0)
			return aspb_pkg::IDX_W'($urandom_range(0, plan_hist - 1));
		return aspb_pkg::IDX_W'($urandom);
	endfunction

	// Mostly well-formed runs (samples, swap, reads), with noise and stray items.
	task automatic random_traffic(int unsigned count);
		int unsigned done;
		int unsigned burst;
		int unsigned reads;
		int unsigned roll;
		done = 0;
		while (done < count) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				feed(OP_UNUSED, aspb_pkg::CODE_W'($urandom), aspb_pkg::IDX_W'($urandom));
			end else if (roll < 18) begin
				if ($urandom_range(0, 1))
					feed(aspb_pkg::OP_READ, aspb_pkg::CODE_W'($urandom),
						aspb_pkg::IDX_W'($urandom));
				else
					feed(aspb_pkg::OP_SWAP, aspb_pkg::CODE_W'($urandom),
						aspb_pkg::IDX_W'($urandom));
				done++;
			end else begin
				burst = $urandom_range(1, 40);
				repeat (burst) feed(aspb_pkg::OP_SAMPLE, pick_code(), aspb_pkg::IDX_W'($urandom));
				feed(aspb_pkg::OP_SWAP, aspb_pkg::CODE_W'($urandom), aspb_pkg::IDX_W'($urandom));
				reads = $urandom_range(1, 8);
				repeat (reads) feed(aspb_pkg::OP_READ, aspb_pkg::CODE_W'($urandom),
					pick_history_index());
				done += burst + 1 + reads;
			end
		end
	endtask

	// Waits until every queued item is sent and every result has arrived.
	task automatic wait_idle();
		@(negedge clk);
		while (sample_feed.size() != 0 || s_tvalid || pending_readings.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic set_weight(logic [aspb_pkg::WGT_W-1:0] w);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= w;
		@(posedge clk);
		cfg_wen <= 1'b0;
		weight_q16 = w;
	endtask

	// Stimulus sequence, phase by phase.
	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty history, unused code, code extremes, swaps and reads at the edges.
		feed(aspb_pkg::OP_READ, 12'd0, 10'd0);
		feed(OP_UNUSED, 12'hFFF, 10'h3FF);
		feed(aspb_pkg::OP_SAMPLE, 12'd4095, 10'd0);
		feed(aspb_pkg::OP_SAMPLE, 12'd0, 10'd0);
		feed(aspb_pkg::OP_SAMPLE, 12'd1, 10'd0);
		feed(aspb_pkg::OP_SAMPLE, 12'd2048, 10'd0);
		feed(aspb_pkg::OP_SAMPLE, 12'hAAA, 10'h155);
		feed(aspb_pkg::OP_SAMPLE, 12'h555, 10'h2AA);
		feed(aspb_pkg::OP_SAMPLE, 12'd4094, 10'd0);
		feed(aspb_pkg::OP_SWAP, 12'd0, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd6);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd7);
		feed(aspb_pkg::OP_READ, 12'hFFF, 10'd1023);
		feed(OP_UNUSED, 12'd0, 10'd0);
		feed(aspb_pkg::OP_SWAP, 12'd0, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd0);
		feed(aspb_pkg::OP_SWAP, 12'd0, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd3);
		feed(aspb_pkg::OP_SAMPLE, 12'hFFF, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'h2AA);
		feed(aspb_pkg::OP_READ, 12'd0, 10'h155);
		wait_idle();

		// Weight zero: the average follows each sample; no idling on either side.
		set_weight(16'd0);
		calm = 1'b1;
		random_traffic(150);
		wait_idle();
		calm = 1'b0;

		// Largest weight: fill a bank past its depth, then read both ends of the history and ten picked indices.
		set_weight(16'hFFFF);
		feed(aspb_pkg::OP_SWAP, 12'd0, 10'd0);
		repeat (BANK_DEPTH + 6) feed(aspb_pkg::OP_SAMPLE, pick_code(),
			aspb_pkg::IDX_W'($urandom));
		feed(aspb_pkg::OP_SWAP, 12'd0, 10'd0);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd1023);
		feed(aspb_pkg::OP_READ, 12'd0, 10'd0);
		repeat (10) feed(aspb_pkg::OP_READ, aspb_pkg::CODE_W'($urandom), pick_history_index());
		wait_idle();

		set_weight(16'd1);
		random_traffic(300);
		wait_idle();

		set_weight(16'd32768);
		random_traffic(200);
		wait_idle();

		set_weight(aspb_pkg::WGT_W'($urandom));
		random_traffic(250);
		wait_idle();
		repeat (LATENCY * 4) @(posedge clk);

		if (pending_readings.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_readings.size());
		end
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

// ===== files.f =====
sv/aspb_pkg.sv
sv/aspb_bank_ram.sv
sv/aspb_convert.sv
sv/aspb_average.sv
sv/adc_sample_ema_pingpong_buffer.sv
tb/testbench.sv
